// ===== hdl/pbd_pkg.sv =====
// Shared types and constants for the PackBits segment decoder.
package pbd_pkg;

    // Segment pixel counter width, fixed by the pixels_per_segment register
    localparam int PIX_W = 21;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Control byte codes
    localparam logic [7:0] LITERAL_MAX = 8'd127;
    localparam logic [7:0] NOOP_CODE   = 8'd128;
    localparam logic [8:0] REPEAT_BASE = 9'd257;

    // Result byte counts
    localparam logic [1:0] ONE_BYTE  = 2'd1;
    localparam logic [1:0] TWO_BYTES = 2'd2;

    // Decoder phase, one-hot
    typedef enum logic [3:0] {
        PH_CONTROL = 4'b0001,
        PH_LITERAL = 4'b0010,
        PH_REPEAT  = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    // One expansion command: repeat value run_len times (a literal is a run of one)
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] run_len;
        logic       done;
        logic       ovr;
    } run_cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_CW-1:0] level;
    } queue_status_t;

endpackage

// ===== hdl/pbd_if.sv =====
// Valid/ready channel interfaces for compressed input and decoded output.
interface pbd_in_if;
    logic       valid;
    logic       ready;
    logic       segment_start;
    logic [7:0] data_byte;

    modport source (output valid, output segment_start, output data_byte, input ready);
    modport sink   (input valid, input segment_start, input data_byte, output ready);
endinterface

interface pbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       segment_done;
    logic       overrun;

    modport source (output valid, output first_byte, output second_byte, output byte_count,
                    output segment_done, output overrun, input ready);
    modport sink   (input valid, input first_byte, input second_byte, input byte_count,
                    input segment_done, input overrun, output ready);
endinterface

// ===== hdl/pbd_front.sv =====
// Front end: accepts compressed bytes, tracks segment state, issues run commands.
module pbd_front #(
    parameter int unsigned MAX_SEGMENT_PIXELS = 1048576
) (
    input  logic                    clk,
    input  logic                    rst_n,
    pbd_in_if.sink                  compressed,
    input  logic [pbd_pkg::PIX_W-1:0] pixels_per_segment,
    input  logic                    queue_full,
    output logic                    push,
    output pbd_pkg::run_cmd_t       push_cmd
);
    import pbd_pkg::*;

    localparam int unsigned PIX_MAX = (1 << PIX_W) - 1;
    localparam int unsigned CAP     = (MAX_SEGMENT_PIXELS > PIX_MAX) ? PIX_MAX
                                                                     : MAX_SEGMENT_PIXELS;
    localparam logic [PIX_W-1:0] CAP_W = PIX_W'(CAP);

    phase_t           phase_reg, phase_next;
    logic [7:0]       count_left_reg, count_left_next;
    logic [PIX_W-1:0] pixels_done_reg, pixels_done_next;

    phase_t           ph;
    logic [7:0]       cl;
    logic [PIX_W-1:0] pd;
    logic [PIX_W-1:0] target;
    logic [PIX_W-1:0] remaining;
    logic [PIX_W-1:0] cl_ext;
    logic [PIX_W-1:0] pd_plus1;
    logic [7:0]       cl_minus1;
    logic [7:0]       run_n;
    logic             accept;

    assign compressed.ready = !queue_full;
    assign accept = compressed.valid && compressed.ready;

    // Clamp the segment target to the configured ceiling
    assign target = (pixels_per_segment > CAP_W) ? CAP_W : pixels_per_segment;

    // Segment start clears state ahead of this byte
    assign ph = compressed.segment_start ? PH_CONTROL : phase_reg;
    assign cl = compressed.segment_start ? 8'd0 : count_left_reg;
    assign pd = compressed.segment_start ? '0 : pixels_done_reg;

    assign remaining = target - pd;
    assign cl_ext    = PIX_W'(cl);
    assign pd_plus1  = pd + PIX_W'(1);
    assign cl_minus1 = cl - 8'd1;
    assign run_n     = (remaining > cl_ext) ? cl : remaining[7:0];

    // Classify the byte and advance segment state
    always_comb
    begin
        phase_next       = phase_reg;
        count_left_next  = count_left_reg;
        pixels_done_next = pixels_done_reg;
        push             = 1'b0;
        push_cmd         = '0;
        push_cmd.value   = compressed.data_byte;
        if (accept)
        begin
            phase_next       = ph;
            count_left_next  = cl;
            pixels_done_next = pd;
            priority if (ph == PH_DONE)
            begin
                phase_next = PH_DONE;
            end
            else if (pd >= target)
            begin
                phase_next      = PH_DONE;
                count_left_next = 8'd0;
            end
            else
            begin
                unique case (ph)
                    PH_CONTROL:
                    begin
                        if (compressed.data_byte <= LITERAL_MAX)
                        begin
                            count_left_next = compressed.data_byte + 8'd1;
                            phase_next      = PH_LITERAL;
                        end
                        else if (compressed.data_byte != NOOP_CODE)
                        begin
                            count_left_next = 8'(REPEAT_BASE - {1'b0, compressed.data_byte});
                            phase_next      = PH_REPEAT;
                        end
                    end
                    PH_LITERAL:
                    begin
                        push             = 1'b1;
                        push_cmd.run_len = 8'd1;
                        push_cmd.done    = (pd_plus1 == target);
                        push_cmd.ovr     = (pd_plus1 == target) && (cl_minus1 != 8'd0);
                        pixels_done_next = pd_plus1;
                        if (pd_plus1 == target)
                        begin
                            phase_next      = PH_DONE;
                            count_left_next = 8'd0;
                        end
                        else
                        begin
                            count_left_next = cl_minus1;
                            if (cl_minus1 == 8'd0)
                            begin
                                phase_next = PH_CONTROL;
                            end
                        end
                    end
                    PH_REPEAT:
                    begin
                        push             = 1'b1;
                        push_cmd.run_len = run_n;
                        push_cmd.done    = (cl_ext >= remaining);
                        push_cmd.ovr     = (remaining < cl_ext);
                        pixels_done_next = pd + PIX_W'(run_n);
                        count_left_next  = 8'd0;
                        phase_next       = (cl_ext >= remaining) ? PH_DONE : PH_CONTROL;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    // Hold segment state between bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CONTROL;
            count_left_reg  <= 8'd0;
            pixels_done_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            count_left_reg  <= count_left_next;
            pixels_done_reg <= pixels_done_next;
        end
    end

endmodule

// ===== hdl/pbd_queue.sv =====
// Short command queue between the front end and the expander.
module pbd_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  pbd_pkg::run_cmd_t         push_cmd,
    input  logic                      pop,
    output pbd_pkg::run_cmd_t         head,
    output pbd_pkg::queue_status_t    status
);
    import pbd_pkg::*;

    run_cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]  level_reg, level_next;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        ptr_inc = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
    endfunction

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (level_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (level_reg == '0);
    assign status.level = level_reg;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/pbd_back.sv =====
// Back end: expands queued run commands into one- and two-byte results.
module pbd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pbd_pkg::run_cmd_t      head,
    input  pbd_pkg::queue_status_t status,
    output logic                   pop,
    pbd_out_if.source              decoded
);
    import pbd_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    logic [7:0] cur_left_reg, cur_left_next;
    logic [7:0] cur_value_reg, cur_value_next;
    logic       cur_done_reg, cur_done_next;
    logic       cur_ovr_reg, cur_ovr_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [1:0] count_reg, count_next;
    logic       done_reg, done_next;
    logic       ovr_reg, ovr_next;

    logic out_free;
    logic emit;
    logic two;
    logic last;

    assign out_free = !out_valid_reg || decoded.ready;
    assign emit     = cur_valid_reg && out_free;
    assign two      = (cur_left_reg >= 8'd2);
    assign last     = (cur_left_reg <= 8'd2);
    assign pop      = !status.empty && (!cur_valid_reg || (emit && last));

    // Load the next command or count down the current run
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_left_next  = cur_left_reg;
        cur_value_next = cur_value_reg;
        cur_done_next  = cur_done_reg;
        cur_ovr_next   = cur_ovr_reg;
        priority if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_left_next  = head.run_len;
            cur_value_next = head.value;
            cur_done_next  = head.done;
            cur_ovr_next   = head.ovr;
        end
        else if (emit && last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            cur_left_next = cur_left_reg - 8'd2;
        end
    end

    // Fill the output register when it frees up
    always_comb
    begin
        out_valid_next = out_valid_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        ovr_next       = ovr_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            first_next     = cur_value_reg;
            second_next    = two ? cur_value_reg : 8'd0;
            count_next     = two ? TWO_BYTES : ONE_BYTE;
            done_next      = last && cur_done_reg;
            ovr_next       = last && cur_ovr_reg;
        end
        else if (decoded.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        cur_left_reg  <= cur_left_next;
        cur_value_reg <= cur_value_next;
        cur_done_reg  <= cur_done_next;
        cur_ovr_reg   <= cur_ovr_next;
        first_reg     <= first_next;
        second_reg    <= second_next;
        count_reg     <= count_next;
        done_reg      <= done_next;
        ovr_reg       <= ovr_next;
    end

    assign decoded.valid        = out_valid_reg;
    assign decoded.first_byte   = first_reg;
    assign decoded.second_byte  = second_reg;
    assign decoded.byte_count   = count_reg;
    assign decoded.segment_done = done_reg;
    assign decoded.overrun      = ovr_reg;

endmodule

// ===== hdl/packbits_rle_segment_decoder_core.sv =====
// Top level of the PackBits segment decoder: front end, command queue, expander.
//
// Usage:
//   compressed: one PackBits byte per request, with segment_start marking the
//     first byte of a new segment. A request is taken when valid and ready are high.
//   decoded: results of one or two decoded bytes; segment_done marks the result
//     that reaches pixels_per_segment, overrun marks a run cut short there.
//   cfg_we/cfg_wdata: write pixels_per_segment; write only while the block is idle.
// Timing:
//   The first result of a data byte reaches the decoded port through the command
//   queue, the expander's current-run register and the output register.
//   Control and literal bytes are taken one per cycle while the queue is not full.
//   A run of n bytes leaves the expander at two bytes per cycle unless decoded is
//   stalled, and the front end keeps taking bytes until the four-entry queue fills.
// Reset: phase returns to control, counters and pixels_per_segment clear, the
//   queue and output register empty; decoding starts as a fresh segment.
// Stall: when decoded.ready is low the output register holds, the expander
//   waits, the queue fills, and compressed.ready drops.
module packbits_rle_segment_decoder_core #(
    parameter int unsigned MAX_SEGMENT_PIXELS = 1048576
) (
    input  logic                      clk,
    input  logic                      rst_n,
    pbd_in_if.sink                    compressed,
    pbd_out_if.source                 decoded,
    input  logic                      cfg_we,
    input  logic [pbd_pkg::PIX_W-1:0] cfg_wdata
);
    import pbd_pkg::*;

    logic [PIX_W-1:0] pixels_per_segment_reg;
    logic             push;
    logic             pop;
    run_cmd_t         push_cmd;
    run_cmd_t         head;
    queue_status_t    status;

    // Hold the segment length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_per_segment_reg <= '0;
        end
        else if (cfg_we)
        begin
            pixels_per_segment_reg <= cfg_wdata;
        end
    end

    pbd_front #(
        .MAX_SEGMENT_PIXELS (MAX_SEGMENT_PIXELS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .compressed         (compressed),
        .pixels_per_segment (pixels_per_segment_reg),
        .queue_full         (status.full),
        .push               (push),
        .push_cmd           (push_cmd)
    );

    pbd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    pbd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .status  (status),
        .pop     (pop),
        .decoded (decoded)
    );

    // Queue never exceeds its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.level <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("command queue level beyond depth");

    // No push lands on a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full command queue");

    // An overrun is only flagged on the segment's final result
    a_overrun_done: assert property (@(posedge clk) disable iff (!rst_n)
        (decoded.valid && decoded.overrun) |-> decoded.segment_done)
        else $error("overrun without segment_done");

    // A single-byte result carries a zero second byte
    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (decoded.valid && decoded.byte_count == ONE_BYTE) |-> (decoded.second_byte == 8'd0))
        else $error("second byte set on single-byte result");

endmodule
